>>> src/quaternion_flower_holonomy_defines.svh
// assertion macros for the flower holonomy checker
// expects clk and rst_n in the scope of use
`ifndef QUATERNION_FLOWER_HOLONOMY_DEFINES_SVH
`define QUATERNION_FLOWER_HOLONOMY_DEFINES_SVH

// same-cycle implication, off during reset
`define QFH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define QFH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/qfh_pkg.sv
// shared constants, types and helper functions of the flower holonomy block
// no dependencies
package qfh_pkg;

    localparam int MAX_FLOWER   = 16;
    localparam int CORDIC_STEPS = 32;

    localparam int ANG_W   = 32;
    localparam int Q_W     = 32;
    localparam int TURN_W  = 36;
    localparam int CW      = 34;
    localparam int PROD_W  = 62;
    localparam int ACC_W   = 64;

    localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);
    localparam int EDGE_W       = $clog2(MAX_FLOWER);
    localparam int NUM_OPS      = 20;
    localparam int OP_W         = $clog2(NUM_OPS);
    localparam int MAC_CNT_W    = $clog2(NUM_OPS + 2);
    localparam int SEL_W        = 3;

    localparam logic signed [ANG_W-1:0] CORNER_RESET = 32'sd562209904;
    localparam logic signed [Q_W-1:0]   ONE_Q30      = 32'sh4000_0000;
    localparam logic signed [CW-1:0]    HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [CW-1:0]    PI_Q30       = 34'sd3373259426;
    localparam logic signed [CW-1:0]    CORDIC_GAIN  = 34'sd652032874;

    localparam logic signed [CW-1:0] ATAN_HEAD [10] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
        34'sd33543515,  34'sd16775850,  34'sd8388437,   34'sd4194282,   34'sd2097149
    };

    // operand selects of the multiply unit
    localparam logic [SEL_W-1:0] A_CA = 3'd0;
    localparam logic [SEL_W-1:0] A_SA = 3'd1;
    localparam logic [SEL_W-1:0] A_RW = 3'd2;
    localparam logic [SEL_W-1:0] A_RX = 3'd3;
    localparam logic [SEL_W-1:0] A_RY = 3'd4;
    localparam logic [SEL_W-1:0] A_RZ = 3'd5;

    localparam logic [SEL_W-1:0] B_CB = 3'd0;
    localparam logic [SEL_W-1:0] B_SB = 3'd1;
    localparam logic [SEL_W-1:0] B_TW = 3'd2;
    localparam logic [SEL_W-1:0] B_TX = 3'd3;
    localparam logic [SEL_W-1:0] B_TY = 3'd4;
    localparam logic [SEL_W-1:0] B_TZ = 3'd5;

    // result destinations: step quaternion, then new running product
    localparam logic [SEL_W-1:0] D_TW = 3'd0;
    localparam logic [SEL_W-1:0] D_TX = 3'd1;
    localparam logic [SEL_W-1:0] D_TY = 3'd2;
    localparam logic [SEL_W-1:0] D_TZ = 3'd3;
    localparam logic [SEL_W-1:0] D_RW = 3'd4;
    localparam logic [SEL_W-1:0] D_RX = 3'd5;
    localparam logic [SEL_W-1:0] D_RY = 3'd6;
    localparam logic [SEL_W-1:0] D_RZ = 3'd7;

    typedef struct packed {
        logic signed [Q_W-1:0] w;
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
    } quat_t;

    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] c;
        logic signed [Q_W-1:0] s;
    } cordic_res_t;

    typedef struct packed {
        logic            issue;
        logic [OP_W-1:0] op;
    } mac_ctl_t;

    typedef struct packed {
        logic [SEL_W-1:0] a_sel;
        logic [SEL_W-1:0] b_sel;
        logic             neg;
        logic             first;
        logic             last;
        logic [SEL_W-1:0] dst;
    } mac_op_t;

    function automatic mac_op_t op_word(input logic [SEL_W-1:0] a, input logic [SEL_W-1:0] b,
                                        input logic neg, input logic first, input logic last,
                                        input logic [SEL_W-1:0] dst);
        mac_op_t o;
        o.a_sel = a;
        o.b_sel = b;
        o.neg   = neg;
        o.first = first;
        o.last  = last;
        o.dst   = dst;
        return o;
    endfunction

    // micro-op list: step quaternion, then hamilton product run * step
    function automatic mac_op_t mac_op(input logic [OP_W-1:0] idx);
        mac_op_t o;
        case (idx)
            5'd0:    o = op_word(A_CA, B_CB, 1'b0, 1'b1, 1'b1, D_TW);
            5'd1:    o = op_word(A_CA, B_SB, 1'b1, 1'b1, 1'b1, D_TX);
            5'd2:    o = op_word(A_SA, B_SB, 1'b1, 1'b1, 1'b1, D_TY);
            5'd3:    o = op_word(A_SA, B_CB, 1'b0, 1'b1, 1'b1, D_TZ);
            5'd4:    o = op_word(A_RW, B_TW, 1'b0, 1'b1, 1'b0, D_RW);
            5'd5:    o = op_word(A_RX, B_TX, 1'b1, 1'b0, 1'b0, D_RW);
            5'd6:    o = op_word(A_RY, B_TY, 1'b1, 1'b0, 1'b0, D_RW);
            5'd7:    o = op_word(A_RZ, B_TZ, 1'b1, 1'b0, 1'b1, D_RW);
            5'd8:    o = op_word(A_RW, B_TX, 1'b0, 1'b1, 1'b0, D_RX);
            5'd9:    o = op_word(A_RX, B_TW, 1'b0, 1'b0, 1'b0, D_RX);
            5'd10:   o = op_word(A_RY, B_TZ, 1'b0, 1'b0, 1'b0, D_RX);
            5'd11:   o = op_word(A_RZ, B_TY, 1'b1, 1'b0, 1'b1, D_RX);
            5'd12:   o = op_word(A_RW, B_TY, 1'b0, 1'b1, 1'b0, D_RY);
            5'd13:   o = op_word(A_RX, B_TZ, 1'b1, 1'b0, 1'b0, D_RY);
            5'd14:   o = op_word(A_RY, B_TW, 1'b0, 1'b0, 1'b0, D_RY);
            5'd15:   o = op_word(A_RZ, B_TX, 1'b0, 1'b0, 1'b1, D_RY);
            5'd16:   o = op_word(A_RW, B_TZ, 1'b0, 1'b1, 1'b0, D_RZ);
            5'd17:   o = op_word(A_RX, B_TY, 1'b0, 1'b0, 1'b0, D_RZ);
            5'd18:   o = op_word(A_RY, B_TX, 1'b1, 1'b0, 1'b0, D_RZ);
            5'd19:   o = op_word(A_RZ, B_TW, 1'b0, 1'b0, 1'b1, D_RZ);
            default: o = op_word(A_CA, B_CB, 1'b0, 1'b1, 1'b0, D_TW);
        endcase
        return o;
    endfunction

    function automatic logic signed [CW-1:0] atan_entry(input logic [CORDIC_IDX_W-1:0] i);
        logic signed [CW-1:0] v;
        logic signed [63:0]   p;
        int                   sh;
        sh = 30 - int'(i);
        p  = 64'sd0;
        if (i < 10) begin
            v = ATAN_HEAD[i[3:0]];
        end
        else if (i < 30) begin
            p = (64'sd1 <<< sh) - 64'sd1;
            v = p[CW-1:0];
        end
        else begin
            v = '0;
        end
        return v;
    endfunction

    function automatic logic signed [Q_W-1:0] sat_cw(input logic signed [CW-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    // q58 sum to q2.30, round half up, saturate
    function automatic logic signed [Q_W-1:0] round_q30(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic signed [35:0]      r;
        logic signed [Q_W-1:0]   o;
        t = acc + 64'sd134217728;
        r = t[63:28];
        if (r > 36'sh0_7FFF_FFFF) begin
            o = 32'sh7FFF_FFFF;
        end
        else if (r < 36'shF_8000_0000) begin
            o = 32'sh8000_0000;
        end
        else begin
            o = r[Q_W-1:0];
        end
        return o;
    endfunction

endpackage

>>> src/qfh_ifs.sv
// handshake channel interfaces: bend requests, flower results, corner angle writes
// depends on qfh_pkg
interface qfh_bend_if import qfh_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] bend_angle;
    logic                    last_in_flower;

    modport source (output valid, bend_angle, last_in_flower, input ready);
    modport sink   (input valid, bend_angle, last_in_flower, output ready);
endinterface

interface qfh_flower_if import qfh_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [Q_W-1:0]    rot_x;
    logic signed [Q_W-1:0]    rot_y;
    logic signed [Q_W-1:0]    rot_z;
    logic signed [TURN_W-1:0] turn_total;
    logic                     dented;

    modport source (output valid, rot_x, rot_y, rot_z, turn_total, dented, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, turn_total, dented, output ready);
endinterface

interface qfh_cfg_if import qfh_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] corner_angle;

    modport source (output valid, corner_angle, input ready);
    modport sink   (input valid, corner_angle, output ready);
endinterface

>>> src/qfh_cordic.sv
// iterative cordic giving cosine and sine of a q2.30 angle, one rotation per cycle
// depends on qfh_pkg
module qfh_cordic import qfh_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ANG_W-1:0] angle,
    output cordic_res_t             res
);

    logic                    busy_reg, busy_next;
    logic                    fin_reg, fin_next;
    logic                    done_reg, done_next;
    logic [CORDIC_IDX_W-1:0] idx_reg, idx_next;
    logic signed [CW-1:0]    x_reg, x_next;
    logic signed [CW-1:0]    y_reg, y_next;
    logic signed [CW-1:0]    z_reg, z_next;
    logic                    neg_reg, neg_next;
    logic signed [Q_W-1:0]   c_reg, c_next;
    logic signed [Q_W-1:0]   s_reg, s_next;

    logic signed [CW-1:0] z_in;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;

    assign z_in = {{(CW - ANG_W){angle[ANG_W-1]}}, angle};
    assign dx   = y_reg >>> idx_reg;
    assign dy   = x_reg >>> idx_reg;
    assign at   = atan_entry(idx_reg);

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        idx_next  = idx_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        neg_next  = neg_reg;
        c_next    = c_reg;
        s_next    = s_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            // fold into +-pi/2, flip the results later
            if (z_in > HALF_PI_Q30)
            begin
                z_next   = z_in - PI_Q30;
                neg_next = 1'b1;
            end
            else if (z_in < -HALF_PI_Q30)
            begin
                z_next   = z_in + PI_Q30;
                neg_next = 1'b1;
            end
            else
            begin
                z_next   = z_in;
                neg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            if (idx_reg == CORDIC_IDX_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (fin_reg)
        begin
            c_next    = sat_cw(neg_reg ? -x_reg : x_reg);
            s_next    = sat_cw(neg_reg ? -y_reg : y_reg);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
        c_reg   <= c_next;
        s_reg   <= s_next;
    end

    assign res.done = done_reg;
    assign res.c    = c_reg;
    assign res.s    = s_reg;

endmodule

>>> src/qfh_mac.sv
// shared multiply-accumulate unit: step quaternion and hamilton product, one product a cycle
// depends on qfh_pkg
module qfh_mac import qfh_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mac_ctl_t              ctl,
    input  logic signed [Q_W-1:0] ca,
    input  logic signed [Q_W-1:0] sa,
    input  logic signed [Q_W-1:0] cb,
    input  logic signed [Q_W-1:0] sb,
    input  quat_t                 run,
    output quat_t                 prod
);

    mac_op_t                 op_d;
    logic signed [Q_W-1:0]   a_opnd;
    logic signed [Q_W-1:0]   b_opnd;
    logic signed [63:0]      full;
    logic signed [ACC_W-1:0] prod_ext;

    logic                    p1_valid_reg;
    mac_op_t                 p1_op_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                    a2_valid_reg;
    logic                    a2_last_reg;
    logic [SEL_W-1:0]        a2_dst_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    quat_t                   step_reg;
    quat_t                   res_reg;
    logic signed [Q_W-1:0]   rounded;

    assign op_d = mac_op(ctl.op);

    always_comb
    begin
        case (op_d.a_sel)
            A_CA:    a_opnd = ca;
            A_SA:    a_opnd = sa;
            A_RW:    a_opnd = run.w;
            A_RX:    a_opnd = run.x;
            A_RY:    a_opnd = run.y;
            A_RZ:    a_opnd = run.z;
            default: a_opnd = '0;
        endcase
        case (op_d.b_sel)
            B_CB:    b_opnd = cb;
            B_SB:    b_opnd = sb;
            B_TW:    b_opnd = step_reg.w;
            B_TX:    b_opnd = step_reg.x;
            B_TY:    b_opnd = step_reg.y;
            B_TZ:    b_opnd = step_reg.z;
            default: b_opnd = '0;
        endcase
    end

    // q2.30 x q2.30 floored to q58
    assign full     = a_opnd * b_opnd;
    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_next = (p1_op_reg.first ? '0 : acc_reg)
                    + (p1_op_reg.neg ? -prod_ext : prod_ext);
    assign rounded  = round_q30(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            a2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= ctl.issue;
            a2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_op_reg   <= op_d;
        prod_reg    <= full[63:2];
        a2_last_reg <= p1_op_reg.last;
        a2_dst_reg  <= p1_op_reg.dst;
        if (p1_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (a2_valid_reg && a2_last_reg)
        begin
            case (a2_dst_reg)
                D_TW:    step_reg.w <= rounded;
                D_TX:    step_reg.x <= rounded;
                D_TY:    step_reg.y <= rounded;
                D_TZ:    step_reg.z <= rounded;
                D_RW:    res_reg.w  <= rounded;
                D_RX:    res_reg.x  <= rounded;
                D_RY:    res_reg.y  <= rounded;
                D_RZ:    res_reg.z  <= rounded;
                default: res_reg.z  <= rounded;
            endcase
        end
    end

    assign prod = res_reg;

endmodule

>>> src/quaternion_flower_holonomy.sv
// Flower holonomy unit: each bend request multiplies the step quaternion
// qz(corner) * qx(-bend) onto a running product and adds the bend to a turn sum;
// the last edge of a flower (or its MAX_FLOWER-th) gives rot_x/y/z, turn_total and
// dented, then the state returns to identity and zero. For each request the bend
// cordic runs one rotation a cycle, then the single 32x32 multiply-accumulate unit
// works through 20 products and its product and accumulate stages drain, then S_FIN
// commits, waiting while a closing result would meet a full output register.
// bend_in.ready is low meanwhile. The first request after reset or after a
// corner_angle write first has the same cordic turn the corner angle. A finished
// result waits in an output register while the next request is taken.
module quaternion_flower_holonomy import qfh_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    qfh_cfg_if.sink      cfg,
    qfh_bend_if.sink     bend_in,
    qfh_flower_if.source flower_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CORN = 3'd1;
    localparam logic [2:0] S_BEND = 3'd2;
    localparam logic [2:0] S_MAC  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic signed [ANG_W-1:0]  corner_reg;
    logic                     corner_ok_reg;
    logic signed [ANG_W-1:0]  bend_reg;
    logic                     last_reg;
    logic signed [Q_W-1:0]    ca_reg, sa_reg, cb_reg, sb_reg;
    quat_t                    run_reg;
    logic signed [TURN_W-1:0] turn_reg;
    logic [EDGE_W-1:0]        edge_reg;
    logic [MAC_CNT_W-1:0]     mac_cnt_reg;
    logic                     out_valid_reg;
    quat_t                    out_rot_reg;
    logic signed [TURN_W-1:0] out_turn_reg;

    logic                     in_req;
    logic                     out_take;
    logic                     cordic_start;
    logic signed [ANG_W-1:0]  cordic_angle;
    cordic_res_t              cres;
    mac_ctl_t                 mctl;
    quat_t                    mres;
    logic signed [TURN_W:0]   tsum;
    logic signed [TURN_W-1:0] turn_new;
    logic                     close;
    logic                     commit;

    assign bend_in.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign in_req        = bend_in.valid && bend_in.ready;
    assign out_take      = out_valid_reg && flower_out.ready;

    always_comb
    begin
        cordic_start = 1'b0;
        cordic_angle = bend_reg;
        if (state_reg == S_IDLE && in_req)
        begin
            cordic_start = 1'b1;
            cordic_angle = corner_ok_reg ? bend_in.bend_angle : corner_reg;
        end
        else if (state_reg == S_CORN && cres.done)
        begin
            cordic_start = 1'b1;
            cordic_angle = bend_reg;
        end
    end

    qfh_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (cordic_angle),
        .res   (cres)
    );

    assign mctl.issue = (state_reg == S_MAC) && (mac_cnt_reg < MAC_CNT_W'(NUM_OPS));
    assign mctl.op    = OP_W'(mac_cnt_reg);

    qfh_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .ca    (ca_reg),
        .sa    (sa_reg),
        .cb    (cb_reg),
        .sb    (sb_reg),
        .run   (run_reg),
        .prod  (mres)
    );

    // saturating turn sum
    assign tsum = {turn_reg[TURN_W-1], turn_reg}
                + {{(TURN_W + 1 - ANG_W){bend_reg[ANG_W-1]}}, bend_reg};
    always_comb
    begin
        if (tsum[TURN_W] != tsum[TURN_W-1])
        begin
            turn_new = tsum[TURN_W] ? {1'b1, {(TURN_W - 1){1'b0}}}
                                    : {1'b0, {(TURN_W - 1){1'b1}}};
        end
        else
        begin
            turn_new = tsum[TURN_W-1:0];
        end
    end

    assign close  = last_reg || (edge_reg == EDGE_W'(MAX_FLOWER - 1));
    assign commit = (state_reg == S_FIN) && (!close || !out_valid_reg || flower_out.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_req)
                begin
                    state_next = corner_ok_reg ? S_BEND : S_CORN;
                end
            end
            S_CORN:
            begin
                if (cres.done)
                begin
                    state_next = S_BEND;
                end
            end
            S_BEND:
            begin
                if (cres.done)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (mac_cnt_reg == MAC_CNT_W'(NUM_OPS + 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            corner_reg    <= CORNER_RESET;
            corner_ok_reg <= 1'b0;
            run_reg       <= '{w: ONE_Q30, x: '0, y: '0, z: '0};
            turn_reg      <= '0;
            edge_reg      <= '0;
            mac_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                corner_reg    <= cfg.corner_angle;
                corner_ok_reg <= 1'b0;
            end
            else if (state_reg == S_CORN && cres.done)
            begin
                corner_ok_reg <= 1'b1;
            end
            if (state_reg == S_MAC)
            begin
                mac_cnt_reg <= mac_cnt_reg + 1'b1;
            end
            else
            begin
                mac_cnt_reg <= '0;
            end
            if (commit && close)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                if (close)
                begin
                    run_reg  <= '{w: ONE_Q30, x: '0, y: '0, z: '0};
                    turn_reg <= '0;
                    edge_reg <= '0;
                end
                else
                begin
                    run_reg  <= mres;
                    turn_reg <= turn_new;
                    edge_reg <= edge_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            bend_reg <= bend_in.bend_angle;
            last_reg <= bend_in.last_in_flower;
        end
        if (state_reg == S_CORN && cres.done)
        begin
            ca_reg <= cres.c;
            sa_reg <= cres.s;
        end
        if (state_reg == S_BEND && cres.done)
        begin
            cb_reg <= cres.c;
            sb_reg <= cres.s;
        end
        if (commit && close)
        begin
            out_rot_reg  <= mres;
            out_turn_reg <= turn_new;
        end
    end

    assign flower_out.valid      = out_valid_reg;
    assign flower_out.rot_x      = out_rot_reg.x;
    assign flower_out.rot_y      = out_rot_reg.y;
    assign flower_out.rot_z      = out_rot_reg.z;
    assign flower_out.turn_total = out_turn_reg;
    assign flower_out.dented     = out_turn_reg[TURN_W-1];

endmodule

>>> src/qfh_chk.sv
// port-level checker for the flower holonomy block, bound to the top level
// depends on qfh_pkg and quaternion_flower_holonomy_defines.svh
`include "quaternion_flower_holonomy_defines.svh"

module qfh_chk import qfh_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [Q_W-1:0]    rot_x,
    input logic signed [TURN_W-1:0] turn_total,
    input logic                     dented
);

    // a request keeps the block busy for the following cycle
    `QFH_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready after request")

    // a fresh result only comes out of a busy cycle
    `QFH_ASSERT_IMP(a_result_from_busy, $rose(out_valid), $past(!in_ready), "result while idle")

    `QFH_ASSERT_IMP(a_dent_sign, out_valid, dented == turn_total[TURN_W-1], "dent flag mismatch")

    // stalled result holds
    `QFH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(rot_x) && $stable(turn_total), "stalled result changed")

endmodule

bind quaternion_flower_holonomy qfh_chk u_qfh_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (bend_in.valid),
    .in_ready   (bend_in.ready),
    .out_valid  (flower_out.valid),
    .out_ready  (flower_out.ready),
    .rot_x      (flower_out.rot_x),
    .turn_total (flower_out.turn_total),
    .dented     (flower_out.dented)
);
